// ----- hdl/button_press_classifier_unit_defines.svh -----
// Assertion macros shared by the button press classifier.
`ifndef BUTTON_PRESS_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define BPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/bpc_pkg.sv -----
// Types, codes and helpers shared by the button press classifier.
package bpc_pkg;

    // Gesture queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Item kinds
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_ENQUEUE = 1'b1;

    // Buttons a gesture may drive
    localparam logic [1:0] BTN_PLUS  = 2'd0;
    localparam logic [1:0] BTN_POWER = 2'd1;
    localparam logic [1:0] BTN_BOOT  = 2'd2;

    // Reported events
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_PLUS  = 2'd1;
    localparam logic [1:0] EV_POWER = 2'd2;

    // Register indexes on the configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_SAMPLES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_OFF_HOLD_MS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOOT_GRACE_MS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOOT_SHORT_MAX_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GESTURE_RELEASE_MS = 3'd4;
    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic        op;
        logic [31:0] now_ms;
        logic        plus_raw;
        logic        power_raw;
        logic        boot_raw;
        logic [1:0]  gesture_button;
        logic [31:0] gesture_hold_ms;
    } item_t;

    typedef struct packed {
        logic [1:0] button_event;
        logic       power_off_request;
        logic       reboot_request;
        logic       enqueue_full;
    } result_t;

    typedef struct packed {
        logic [7:0]  debounce_samples;
        logic [15:0] power_off_hold_ms;
        logic [15:0] boot_grace_ms;
        logic [15:0] boot_short_max_ms;
        logic [15:0] gesture_release_ms;
    } cfg_t;

    // Button levels after the gesture override
    typedef struct packed {
        logic plus;
        logic power;
        logic boot;
    } levels_t;

    // Per-button outcome of the debouncer
    typedef struct packed {
        logic       accept;
        logic [7:0] cnt;
    } deb_t;

    // Sample-count debouncer: a differing level counts up (saturating) and is
    // taken once the count reaches the threshold; a matching level clears it.
    function automatic deb_t debounce(input logic raw, input logic lvl,
                                      input logic [7:0] cnt, input logic [7:0] samples);
        deb_t       r;
        logic [7:0] inc;
        inc = (cnt != 8'hFF) ? cnt + 8'd1 : cnt;
        r.accept = 1'b0;
        r.cnt    = 8'd0;
        if (raw != lvl) begin
            if (inc >= samples) begin
                r.accept = 1'b1;
            end
            else begin
                r.cnt = inc;
            end
        end
        return r;
    endfunction

endpackage

// ----- hdl/button_press_classifier_unit.sv -----
// Top level of the button press classifier: channels, configuration and pipeline registers.
//
// Usage:
//   item channel (item_valid/item_ready/item): a tick beat carries the time and
//   the three raw button levels; an enqueue beat queues a synthetic gesture.
//   result channel (result_valid/result_ready/result): one result beat per item,
//   in order: button event, power-off and reboot pulses, queue-full flag.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//   always ready; write only while no item is in flight.
// Path: an accepted item beat lands in the input register; the result register
//   loads from it when the result register is free or its result is being taken.
// Throughput: one item per cycle unless result_ready stalls; the rate is set by the
//   single pass of logic between the input register and the result register.
// Reset: registers take their reset values, the gesture queue is empty and
//   all buttons read released and armed; no result is pending.
// Stall: while result_ready is low the result holds; one more item waits in
//   the input register, after which item_ready drops.
module button_press_classifier_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  bpc_pkg::item_t                     item,
    output logic                               result_valid,
    input  logic                               result_ready,
    output bpc_pkg::result_t                   result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

`include "button_press_classifier_unit_defines.svh"

    bpc_pkg::cfg_t    cfg_reg;
    bpc_pkg::item_t   in_item_reg;
    logic             in_valid_reg;
    bpc_pkg::result_t result_reg, result_next;
    logic             result_valid_reg;

    logic             advance, fire, tick;
    bpc_pkg::levels_t levels;
    logic             q_full;
    logic [1:0]       button_event;
    logic             power_off_request, reboot_request;

    // Handshake: the result register frees up when taken
    assign advance      = !result_valid_reg || result_ready;
    assign fire         = in_valid_reg && advance;
    assign tick         = fire && (in_item_reg.op == bpc_pkg::OP_TICK);
    assign item_ready   = !in_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.debounce_samples   <= 8'd3;
            cfg_reg.power_off_hold_ms  <= 16'd3000;
            cfg_reg.boot_grace_ms      <= 16'd1000;
            cfg_reg.boot_short_max_ms  <= 16'd1000;
            cfg_reg.gesture_release_ms <= 16'd100;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                bpc_pkg::REG_DEBOUNCE_SAMPLES:   cfg_reg.debounce_samples   <= cfg_data[7:0];
                bpc_pkg::REG_POWER_OFF_HOLD_MS:  cfg_reg.power_off_hold_ms  <= cfg_data;
                bpc_pkg::REG_BOOT_GRACE_MS:      cfg_reg.boot_grace_ms      <= cfg_data;
                bpc_pkg::REG_BOOT_SHORT_MAX_MS:  cfg_reg.boot_short_max_ms  <= cfg_data;
                bpc_pkg::REG_GESTURE_RELEASE_MS: cfg_reg.gesture_release_ms <= cfg_data;
                default:                         ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (item_valid && item_ready) begin
            in_valid_reg <= 1'b1;
        end
        else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready) begin
            in_item_reg <= item;
        end
    end

    bpc_gesture_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .levels (levels),
        .full   (q_full)
    );

    bpc_buttons u_buttons (
        .clk               (clk),
        .rst_n             (rst_n),
        .tick              (tick),
        .now_ms            (in_item_reg.now_ms),
        .levels            (levels),
        .cfg               (cfg_reg),
        .button_event      (button_event),
        .power_off_request (power_off_request),
        .reboot_request    (reboot_request)
    );

    // Result assembly: enqueue beats only report the full flag
    always_comb
    begin
        if (in_item_reg.op == bpc_pkg::OP_ENQUEUE) begin
            result_next.button_event      = bpc_pkg::EV_NONE;
            result_next.power_off_request = 1'b0;
            result_next.reboot_request    = 1'b0;
            result_next.enqueue_full      = q_full;
        end
        else begin
            result_next.button_event      = button_event;
            result_next.power_off_request = power_off_request;
            result_next.reboot_request    = reboot_request;
            result_next.enqueue_full      = 1'b0;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
        end
        else if (fire) begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready) begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

    // Checks
    `BPC_ASSERT_NOW(a_ready_only_on_stall, !item_ready,
                    in_valid_reg && result_valid && !result_ready,
                    "item_ready low without a stalled result")
    `BPC_ASSERT_NEXT(a_beat_captured, item_valid && item_ready, in_valid_reg,
                     "accepted item beat not held in the input register")
    `BPC_ASSERT_NOW(a_power_exclusive, result_valid && result.power_off_request,
                    result.button_event != bpc_pkg::EV_POWER && !result.enqueue_full,
                    "power-off request together with a short press or enqueue flag")

endmodule

// ----- hdl/bpc_gesture_queue.sv -----
// Synthetic gesture queue, active gesture timer and button level override.
module bpc_gesture_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  bpc_pkg::item_t     item,
    input  bpc_pkg::cfg_t      cfg,
    output bpc_pkg::levels_t   levels,
    output logic               full
);

    localparam int SUM_W = bpc_pkg::QCNT_W + 1;

    // Queue storage, no reset: an entry is only read after it was written
    logic [1:0]  q_button_reg [bpc_pkg::QUEUE_DEPTH];
    logic [31:0] q_hold_reg   [bpc_pkg::QUEUE_DEPTH];

    logic [bpc_pkg::QIDX_W-1:0] head_reg, head_next;
    logic [bpc_pkg::QCNT_W-1:0] count_reg, count_next;

    logic        act_on_reg;
    logic [1:0]  act_button_reg;
    logic [31:0] act_start_reg;
    logic [31:0] act_hold_reg;

    logic                       is_tick, is_enq;
    logic [SUM_W-1:0]           slot_sum;
    logic [bpc_pkg::QIDX_W-1:0] slot;
    logic [32:0]                end_wide;
    logic [31:0]                end_sat;
    logic                       still_on, load, eff_on;
    logic [1:0]                 eff_button;
    logic [31:0]                eff_start, eff_hold;
    logic                       ovr_level;

    assign is_tick = fire && (item.op == bpc_pkg::OP_TICK);
    assign is_enq  = fire && (item.op == bpc_pkg::OP_ENQUEUE);
    assign full    = (count_reg == bpc_pkg::QCNT_W'(bpc_pkg::QUEUE_DEPTH));

    // Tail slot: head plus count, wrapped once
    always_comb
    begin
        slot_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (slot_sum >= SUM_W'(bpc_pkg::QUEUE_DEPTH)) begin
            slot_sum = slot_sum - SUM_W'(bpc_pkg::QUEUE_DEPTH);
        end
        slot = slot_sum[bpc_pkg::QIDX_W-1:0];
    end

    // Gesture end: hold plus release gap, saturated to 32 bits
    assign end_wide = {1'b0, act_hold_reg} + {17'd0, cfg.gesture_release_ms};
    assign end_sat  = end_wide[32] ? 32'hFFFF_FFFF : end_wide[31:0];

    // Retire the active gesture, then pull the next one from the head
    always_comb
    begin
        still_on   = act_on_reg && ((item.now_ms - act_start_reg) < end_sat);
        load       = !still_on && (count_reg != '0);
        eff_on     = still_on || load;
        eff_button = load ? q_button_reg[head_reg] : act_button_reg;
        eff_start  = load ? item.now_ms : act_start_reg;
        eff_hold   = load ? q_hold_reg[head_reg] : act_hold_reg;
        ovr_level  = (item.now_ms - eff_start) < eff_hold;
    end

    // Level override for the button the gesture names
    always_comb
    begin
        levels.plus  = item.plus_raw;
        levels.power = item.power_raw;
        levels.boot  = item.boot_raw;
        if (eff_on) begin
            case (eff_button)
                bpc_pkg::BTN_PLUS:  levels.plus  = ovr_level;
                bpc_pkg::BTN_POWER: levels.power = ovr_level;
                bpc_pkg::BTN_BOOT:  levels.boot  = ovr_level;
                default:            ;
            endcase
        end
    end

    // Pointer and count updates
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (is_enq && !full) begin
            count_next = count_reg + bpc_pkg::QCNT_W'(1);
        end
        else if (is_tick && load) begin
            count_next = count_reg - bpc_pkg::QCNT_W'(1);
            head_next  = (head_reg == bpc_pkg::QIDX_W'(bpc_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : head_reg + bpc_pkg::QIDX_W'(1);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_reg       <= '0;
            count_reg      <= '0;
            act_on_reg     <= 1'b0;
            act_button_reg <= '0;
            act_start_reg  <= '0;
            act_hold_reg   <= '0;
        end
        else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (is_tick) begin
                act_on_reg <= eff_on;
                if (load) begin
                    act_button_reg <= eff_button;
                    act_start_reg  <= eff_start;
                    act_hold_reg   <= eff_hold;
                end
            end
        end
    end

    // Queue writes
    always_ff @(posedge clk)
    begin
        if (is_enq && !full) begin
            q_button_reg[slot] <= item.gesture_button;
            q_hold_reg[slot]   <= item.gesture_hold_ms;
        end
    end

endmodule

// ----- hdl/bpc_buttons.sv -----
// Debouncers and press classification for the plus, power and boot buttons.
module bpc_buttons (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tick,
    input  logic [31:0]       now_ms,
    input  bpc_pkg::levels_t  levels,
    input  bpc_pkg::cfg_t     cfg,
    output logic [1:0]        button_event,
    output logic              power_off_request,
    output logic              reboot_request
);

    // Power and boot are never disarmed, so only plus keeps an armed flag
    bpc_pkg::levels_t deb_reg, deb_next;
    logic [7:0]  cnt_plus_reg, cnt_power_reg, cnt_boot_reg;
    logic [7:0]  cnt_plus_next, cnt_power_next, cnt_boot_next;
    logic        plus_armed_reg, plus_armed_next;
    logic [31:0] power_start_reg, power_start_next;
    logic        off_sent_reg, off_sent_next;
    logic [31:0] boot_start_reg, boot_start_next;

    bpc_pkg::deb_t d_plus, d_power, d_boot;
    logic          plus_ev, power_ev;
    logic [31:0]   power_dur;

    assign d_plus  = bpc_pkg::debounce(levels.plus, deb_reg.plus, cnt_plus_reg,
                                       cfg.debounce_samples);
    assign d_power = bpc_pkg::debounce(levels.power, deb_reg.power, cnt_power_reg,
                                       cfg.debounce_samples);
    assign d_boot  = bpc_pkg::debounce(levels.boot, deb_reg.boot, cnt_boot_reg,
                                       cfg.debounce_samples);
    assign power_dur = now_ms - power_start_reg;

    always_comb
    begin
        deb_next         = deb_reg;
        plus_armed_next  = plus_armed_reg;
        power_start_next = power_start_reg;
        off_sent_next    = off_sent_reg;
        boot_start_next  = boot_start_reg;
        cnt_plus_next    = d_plus.cnt;
        cnt_power_next   = cnt_power_reg;
        cnt_boot_next    = d_boot.cnt;
        plus_ev          = 1'b0;
        power_ev         = 1'b0;
        power_off_request = 1'b0;
        reboot_request   = 1'b0;

        // Plus: report an accepted press while armed
        if (d_plus.accept) begin
            deb_next.plus = levels.plus;
            if (levels.plus && plus_armed_reg) begin
                plus_armed_next = 1'b0;
                plus_ev         = 1'b1;
            end
            else if (!levels.plus) begin
                plus_armed_next = 1'b1;
            end
        end

        // Power: skipped on a tick where plus reports
        if (!plus_ev) begin
            cnt_power_next = d_power.cnt;
            if (d_power.accept) begin
                deb_next.power = levels.power;
                if (levels.power) begin
                    power_start_next = now_ms;
                end
                else begin
                    power_ev = !off_sent_reg && (power_start_reg != 32'd0) &&
                               (power_dur != 32'd0) &&
                               (power_dur < {16'd0, cfg.power_off_hold_ms});
                    off_sent_next    = 1'b0;
                    power_start_next = 32'd0;
                end
            end
            // Long hold check on the updated state
            if (deb_next.power && !off_sent_next && (power_start_next != 32'd0) &&
                ((now_ms - power_start_next) >= {16'd0, cfg.power_off_hold_ms})) begin
                off_sent_next     = 1'b1;
                power_off_request = 1'b1;
            end
        end

        // Boot: time presses that start after the grace period
        if (d_boot.accept) begin
            deb_next.boot = levels.boot;
            if (levels.boot) begin
                if (now_ms >= {16'd0, cfg.boot_grace_ms}) begin
                    boot_start_next = now_ms;
                end
            end
            else if (boot_start_reg != 32'd0) begin
                reboot_request  = (now_ms - boot_start_reg) <= {16'd0, cfg.boot_short_max_ms};
                boot_start_next = 32'd0;
            end
        end

        if (plus_ev) begin
            button_event = bpc_pkg::EV_PLUS;
        end
        else if (power_ev) begin
            button_event = bpc_pkg::EV_POWER;
        end
        else begin
            button_event = bpc_pkg::EV_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            deb_reg         <= '0;
            cnt_plus_reg    <= '0;
            cnt_power_reg   <= '0;
            cnt_boot_reg    <= '0;
            plus_armed_reg  <= 1'b1;
            power_start_reg <= '0;
            off_sent_reg    <= 1'b0;
            boot_start_reg  <= '0;
        end
        else if (tick) begin
            deb_reg         <= deb_next;
            cnt_plus_reg    <= cnt_plus_next;
            cnt_power_reg   <= cnt_power_next;
            cnt_boot_reg    <= cnt_boot_next;
            plus_armed_reg  <= plus_armed_next;
            power_start_reg <= power_start_next;
            off_sent_reg    <= off_sent_next;
            boot_start_reg  <= boot_start_next;
        end
    end

endmodule
